/* src/fdta_pkg.sv */
// ----------------------------------------------------------------------------
// fdta_pkg
// Constants, control word layout and sequencer program for the fixed-point
// decimal to ASCII formatter.
// ----------------------------------------------------------------------------
package fdta_pkg;

	localparam int FRACTION_DIGITS = 6;

	localparam int IN_W   = 64;
	localparam int NDIG   = 19;
	localparam int BCD_W  = NDIG * 4;
	localparam int IDX_W  = $clog2(NDIG);
	localparam int CNT_W  = $clog2(IN_W);
	localparam int CHAR_W = 7;
	localparam int STEP_W = 3;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DABBLE,
		OP_SIGN,
		OP_SKIP,
		OP_DIGIT,
		OP_POINT
	} op_t;

	typedef enum logic [2:0] {
		CND_NONE,
		CND_ALWAYS,
		CND_IN_WAIT,
		CND_COUNT,
		CND_SKIP,
		CND_NOT_POINT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
	} ctrl_t;

	localparam step_t ST_ENTRY  = 3'd0;
	localparam step_t ST_DABBLE = 3'd1;
	localparam step_t ST_SKIP   = 3'd3;
	localparam step_t ST_DIGIT  = 3'd4;

	// on a taken condition go to jmp, else to the next step;
	// emitting the last char of a value always returns to the entry step
	function automatic ctrl_t prog_rom(input step_t step);
		ctrl_t w;
		case (step)
			3'd0:    w = '{op: OP_LOAD,   cond: CND_IN_WAIT,   jmp: ST_ENTRY};
			3'd1:    w = '{op: OP_DABBLE, cond: CND_COUNT,     jmp: ST_DABBLE};
			3'd2:    w = '{op: OP_SIGN,   cond: CND_NONE,      jmp: ST_ENTRY};
			3'd3:    w = '{op: OP_SKIP,   cond: CND_SKIP,      jmp: ST_SKIP};
			3'd4:    w = '{op: OP_DIGIT,  cond: CND_NOT_POINT, jmp: ST_DIGIT};
			3'd5:    w = '{op: OP_POINT,  cond: CND_ALWAYS,    jmp: ST_DIGIT};
			default: w = '{op: OP_NOP,    cond: CND_ALWAYS,    jmp: ST_ENTRY};
		endcase
		return w;
	endfunction

	// add-3 correction of every BCD digit of 5 or more ahead of a shift
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		r = v;
		for (int d = 0; d < NDIG; d++) begin
			if (v[d*4 +: 4] >= 4'd5) begin
				r[d*4 +: 4] = v[d*4 +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

/* src/fixed_decimal_to_ascii_unit.sv */
// ----------------------------------------------------------------------------
// fixed_decimal_to_ascii_unit
// Formats a signed 64-bit scaled decimal value as ASCII text, one char a beat.
// ----------------------------------------------------------------------------
// One value is taken at a time. Its text leaves most significant char first:
// an optional '-', the integer digits without leading zeros ('0' if none),
// '.', then the fraction digits with trailing zeros dropped (at least one
// kept); tlast marks the final char. A value passes through these steps:
// one load step, 64 shift-and-correct steps of the binary to BCD converter,
// one sign step, then one step per digit position from the top down to the
// lowest nonzero fraction digit (position 0 to FRACTION_DIGITS - 1, zero
// values stopping at FRACTION_DIGITS - 1), one per point and one ending the
// leading zero scan. The next value is taken in the cycle after the last
// char is handed to the output register.
// ----------------------------------------------------------------------------
module fixed_decimal_to_ascii_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] scaled_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [6:0] text_char, [7] zero
	output logic        m_axis_tlast    // last_char
);
	import fdta_pkg::*;

	localparam logic [IDX_W-1:0] FD_IDX  = IDX_W'(FRACTION_DIGITS);
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NDIG - 1);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(IN_W - 1);

	step_t              step_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;
	logic               neg_q;
	logic [IN_W-1:0]    bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;

	ctrl_t              ctrl;
	logic               accept;
	logic               can_emit;
	logic [3:0]         top_dig;
	logic               rest_zero;
	logic               skip_now;
	logic               digit_last;
	logic               hold;
	logic               emit;
	logic [CHAR_W-1:0]  emit_char;
	logic               emit_last;
	logic               cond_hit;
	step_t              step_d;
	logic [IN_W-1:0]    mag;
	logic [BCD_W-1:0]   bcd_adj;

	assign s_axis_tready = (ctrl.op == OP_LOAD);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_char_q};
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		ctrl       = prog_rom(step_q);
		accept     = s_axis_tvalid && s_axis_tready;
		can_emit   = !out_valid_q || m_axis_tready;
		top_dig    = bcd_q[BCD_W-1 -: 4];
		rest_zero  = (bcd_q[BCD_W-5:0] == '0);
		skip_now   = (idx_q > FD_IDX) && (top_dig == 4'd0);
		digit_last = (idx_q < FD_IDX) && rest_zero;
		mag        = s_axis_tdata[IN_W-1] ? (~s_axis_tdata + 64'd1) : s_axis_tdata;
		bcd_adj    = bcd_adjust(bcd_q);

		hold      = 1'b0;
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		case (ctrl.op)
			OP_SIGN: begin
				hold      = neg_q && !can_emit;
				emit      = neg_q && can_emit;
				emit_char = CH_MINUS;
			end
			OP_DIGIT: begin
				hold      = !can_emit;
				emit      = can_emit;
				emit_char = CH_ZERO + {3'b000, top_dig};
				emit_last = digit_last;
			end
			OP_POINT: begin
				hold      = !can_emit;
				emit      = can_emit;
				emit_char = CH_POINT;
			end
			default: begin
				hold = 1'b0;
			end
		endcase

		case (ctrl.cond)
			CND_ALWAYS:    cond_hit = 1'b1;
			CND_IN_WAIT:   cond_hit = !accept;
			CND_COUNT:     cond_hit = (cnt_q != '0);
			CND_SKIP:      cond_hit = skip_now;
			CND_NOT_POINT: cond_hit = (idx_q != FD_IDX);
			default:       cond_hit = 1'b0;
		endcase

		if (hold) begin
			step_d = step_q;
		end else if (emit && emit_last) begin
			step_d = ST_ENTRY;
		end else if (cond_hit) begin
			step_d = ctrl.jmp;
		end else begin
			step_d = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_ENTRY;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
		case (ctrl.op)
			OP_LOAD: begin
				if (accept) begin
					neg_q <= s_axis_tdata[IN_W-1];
					bin_q <= mag;
					bcd_q <= '0;
					cnt_q <= CNT_TOP;
					idx_q <= TOP_IDX;
				end
			end
			OP_DABBLE: begin
				{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
				cnt_q          <= cnt_q - CNT_W'(1);
			end
			OP_SKIP: begin
				if (skip_now) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			OP_DIGIT: begin
				if (can_emit) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule
